/* hdl/pwct_pkg.sv */
// Shared types, constants and helpers for the pulse width code transmitter.
package pwct_pkg;

    localparam int SYMBOLS   = 14;
    localparam int IDX_W     = $clog2(SYMBOLS);
    localparam int PAT_W     = 28;
    localparam int EXT_W     = 32;
    localparam int TICK_W    = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = PAT_W;

    localparam logic [PAT_W-1:0]  RST_PATTERN_FRONT  = PAT_W'(138675264);
    localparam logic [PAT_W-1:0]  RST_PATTERN_GARAGE = PAT_W'(134480960);
    localparam logic [TICK_W-1:0] RST_ZERO_LOW       = TICK_W'(11);
    localparam logic [TICK_W-1:0] RST_ZERO_HIGH      = TICK_W'(6);
    localparam logic [TICK_W-1:0] RST_ONE_LOW        = TICK_W'(5);
    localparam logic [TICK_W-1:0] RST_ONE_HIGH       = TICK_W'(12);
    localparam logic [TICK_W-1:0] RST_PAUSE_LOW      = TICK_W'(204);
    localparam logic [IDX_W-1:0]  LAST_INDEX         = IDX_W'(SYMBOLS - 1);

    typedef enum logic [1:0] {
        SYM_ZERO  = 2'd0,
        SYM_ONE   = 2'd1,
        SYM_PAUSE = 2'd2,
        SYM_RSVD  = 2'd3
    } t_sym;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_FRONT  = 3'd0,
        CFG_PATTERN_GARAGE = 3'd1,
        CFG_ZERO_LOW       = 3'd2,
        CFG_ZERO_HIGH      = 3'd3,
        CFG_ONE_LOW        = 3'd4,
        CFG_ONE_HIGH       = 3'd5,
        CFG_PAUSE_LOW      = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [TICK_W-1:0] zero_low;
        logic [TICK_W-1:0] zero_high;
        logic [TICK_W-1:0] one_low;
        logic [TICK_W-1:0] one_high;
        logic [TICK_W-1:0] pause_low;
    } t_timing;

    // Symbols past the pattern width read as zero symbols.
    function automatic t_sym symbol_at(input logic [PAT_W-1:0] pat,
                                       input logic [IDX_W-1:0] idx);
        logic [EXT_W-1:0] ext;
        ext = EXT_W'(pat);
        return t_sym'(ext[{idx, 1'b0} +: 2]);
    endfunction

    function automatic logic [TICK_W-1:0] phase_length(input t_sym sym,
                                                       input logic high,
                                                       input t_timing tm);
        logic [TICK_W-1:0] len;
        unique case (sym) inside
            SYM_ZERO:            len = high ? tm.zero_high : tm.zero_low;
            SYM_ONE:             len = high ? tm.one_high : tm.one_low;
            SYM_PAUSE, SYM_RSVD: len = high ? '0 : tm.pause_low;
            default:             len = '0;
        endcase
        return len;
    endfunction

endpackage

/* hdl/pulse_width_code_transmitter.sv */
// Pulse width code transmitter: button-started code sender with register port.
//
//  channel | handshake                  | payload
//  --------+----------------------------+-------------------------------------
//  in      | i_valid / o_stall          | i_button_front, i_button_garage, i_tick
//  out     | o_valid / i_stall          | o_tx_level, o_busy_lamp
//  cfg     | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// One beat in, one beat out; a beat is taken every cycle while the output is free.
// The result of a beat is registered and appears in the cycle after it is taken.
// o_stall rises only while a result is held by i_stall.
// Synchronous reset loads the default code and timing and makes the block idle.
module pulse_width_code_transmitter (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic                             i_button_front,
    input  logic                             i_button_garage,
    input  logic                             i_tick,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic                             o_tx_level,
    output logic                             o_busy_lamp,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [pwct_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [pwct_pkg::CFG_W-1:0]       i_cfg_data
);
    import pwct_pkg::*;

    logic [PAT_W-1:0]  r_pattern_front;
    logic [PAT_W-1:0]  r_pattern_garage;
    t_timing           r_timing;

    logic              r_active;
    logic              r_code_select;
    logic [IDX_W-1:0]  r_symbol_index;
    logic [TICK_W-1:0] r_tick_count;
    logic              r_phase_high;
    logic              r_pin_level;
    logic              r_out_valid;

    logic              n_active;
    logic              n_code_select;
    logic [IDX_W-1:0]  n_symbol_index;
    logic [TICK_W-1:0] n_tick_count;
    logic              n_phase_high;
    logic              n_pin_level;

    logic              in_acc;
    logic              out_acc;
    logic              start;
    logic              stop;
    logic [IDX_W-1:0]  cur_index;
    logic [TICK_W-1:0] cur_count;
    logic              cur_phase;
    logic              cur_select;
    logic [TICK_W-1:0] cnt_inc;
    t_sym              sym;

    assign o_stall     = r_out_valid && i_stall;
    assign in_acc      = i_valid && !o_stall;
    assign out_acc     = r_out_valid && !i_stall;
    assign o_valid     = r_out_valid;
    assign o_tx_level  = r_pin_level;
    assign o_busy_lamp = r_active;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_front    <= RST_PATTERN_FRONT;
            r_pattern_garage   <= RST_PATTERN_GARAGE;
            r_timing.zero_low  <= RST_ZERO_LOW;
            r_timing.zero_high <= RST_ZERO_HIGH;
            r_timing.one_low   <= RST_ONE_LOW;
            r_timing.one_high  <= RST_ONE_HIGH;
            r_timing.pause_low <= RST_PAUSE_LOW;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_PATTERN_FRONT:  r_pattern_front    <= i_cfg_data;
                CFG_PATTERN_GARAGE: r_pattern_garage   <= i_cfg_data;
                CFG_ZERO_LOW:       r_timing.zero_low  <= i_cfg_data[TICK_W-1:0];
                CFG_ZERO_HIGH:      r_timing.zero_high <= i_cfg_data[TICK_W-1:0];
                CFG_ONE_LOW:        r_timing.one_low   <= i_cfg_data[TICK_W-1:0];
                CFG_ONE_HIGH:       r_timing.one_high  <= i_cfg_data[TICK_W-1:0];
                CFG_PAUSE_LOW:      r_timing.pause_low <= i_cfg_data[TICK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Start or stop first, then advance the symbol timing on a tick.
    always_comb begin
        start = !r_active && (i_button_front || i_button_garage);
        stop  = r_active && !i_button_front && !i_button_garage;

        n_active   = start ? 1'b1 : (stop ? 1'b0 : r_active);
        cur_select = start ? !i_button_front : r_code_select;
        cur_index  = start ? '0 : r_symbol_index;
        cur_count  = start ? '0 : r_tick_count;
        cur_phase  = start ? 1'b0 : r_phase_high;

        sym     = symbol_at(cur_select ? r_pattern_garage : r_pattern_front, cur_index);
        cnt_inc = cur_count + TICK_W'(1);

        n_code_select  = cur_select;
        n_symbol_index = cur_index;
        n_tick_count   = cur_count;
        n_phase_high   = cur_phase;
        n_pin_level    = r_pin_level;

        if (n_active && i_tick) begin
            n_pin_level  = cur_phase;
            n_tick_count = cnt_inc;
            if (cnt_inc >= phase_length(sym, cur_phase, r_timing)) begin
                if (cur_phase) begin
                    n_symbol_index = (cur_index < LAST_INDEX)
                                   ? cur_index + IDX_W'(1) : '0;
                end
                n_tick_count = '0;
                n_phase_high = !cur_phase;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active       <= 1'b0;
            r_code_select  <= 1'b0;
            r_symbol_index <= '0;
            r_tick_count   <= '0;
            r_phase_high   <= 1'b0;
            r_pin_level    <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (in_acc) begin
                r_active       <= n_active;
                r_code_select  <= n_code_select;
                r_symbol_index <= n_symbol_index;
                r_tick_count   <= n_tick_count;
                r_phase_high   <= n_phase_high;
                r_pin_level    <= n_pin_level;
                r_out_valid    <= 1'b1;
            end else if (out_acc) begin
                r_out_valid    <= 1'b0;
            end
        end
    end

    a_stall_only_when_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_out_valid && i_stall))
        else $error("stall raised without a held result");

    a_index_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_symbol_index <= LAST_INDEX)
        else $error("symbol index past last symbol");

    a_release_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !i_button_front && !i_button_garage) |=> !o_busy_lamp)
        else $error("busy lamp still lit after buttons released");

    a_state_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_acc |=> ($stable(r_symbol_index) && $stable(r_tick_count)
                     && $stable(o_tx_level) && $stable(o_busy_lamp)))
        else $error("state moved without an input beat");

endmodule
